// ----- hdl/pswu_pkg.sv -----
// ----------------------------------------------------------------------------
// pswu_pkg
// Shared types, constants and arithmetic helpers of the steering weight unit.
// ----------------------------------------------------------------------------
package pswu_pkg;

   localparam int TRIG_FRAC  = 30;
   localparam int TERM_STEPS = 7;
   localparam int TRIG_LAT   = 3 * TERM_STEPS + 3;
   localparam int PHASE_W    = 42;
   localparam int PHASE_SH   = 10;

   localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
   localparam logic [62:0] ROUND_32    = 63'd1 << 31;
   localparam logic [60:0] TRIG_HALF   = 61'd1 << 29;
   localparam logic [30:0] TRIG_ONE    = 31'd1 << 30;
   localparam logic [29:0] OCT_SPAN    = 30'd1 << 29;
   localparam logic [PHASE_W-1:0] PHASE_ROUND = PHASE_W'(1) << (PHASE_SH - 1);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   localparam int SIN_DIV   [0:TERM_STEPS-1] = '{6, 20, 42, 72, 110, 156, 210};
   localparam int SIN_SHIFT [0:TERM_STEPS-1] = '{33, 35, 36, 37, 37, 38, 38};
   localparam int COS_DIV   [0:TERM_STEPS-1] = '{2, 12, 30, 56, 90, 132, 182};
   localparam int COS_SHIFT [0:TERM_STEPS-1] = '{31, 34, 35, 36, 37, 38, 38};

   typedef struct packed {
      logic [2:0]  oct;
      logic [29:0] red;
   } angle_split_type;

   typedef struct packed {
      angle_split_type    az;
      angle_split_type    el;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } item_type;

   function automatic angle_split_type split_turn(input logic [31:0] t);
      angle_split_type s;
      s.oct = t[31:29];
      s.red = t[29] ? (OCT_SPAN - {1'b0, t[28:0]}) : {1'b0, t[28:0]};
      return s;
   endfunction

   function automatic logic [30:0] qmul(input logic [30:0] a, input logic [29:0] r);
      logic [60:0] p;
      p = {30'd0, a} * {31'd0, r} + TRIG_HALF;
      return p[60:30];
   endfunction

   function automatic logic [30:0] recip_div(input logic [30:0] x, input logic [31:0] m,
                                             input int sh);
      logic [63:0] p;
      p = {33'd0, x} * {32'd0, m};
      p = p >> sh;
      return p[30:0];
   endfunction

   function automatic logic signed [63:0] round_away(input logic signed [63:0] value,
                                                     input int sh);
      logic [63:0] mag;
      logic [63:0] q;
      mag = value[63] ? (~value + 64'd1) : value;
      q = (mag + (64'd1 << (sh - 1))) >> sh;
      return value[63] ? $signed(~q + 64'd1) : $signed(q);
   endfunction

endpackage

// ----- hdl/pswu_fifo.sv -----
// ----------------------------------------------------------------------------
// pswu_fifo
// Small register queue with full/empty flags and a combinational head.
// ----------------------------------------------------------------------------
module pswu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/pswu_front.sv -----
// ----------------------------------------------------------------------------
// pswu_front
// Input stage: takes a transaction, widens the angles to turns and splits
// them into octant and reduced angle, then hands the item to the queue.
// ----------------------------------------------------------------------------
module pswu_front #(
   parameter int ANGLE_BITS = 16,
   parameter int POS_BITS   = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [ANGLE_BITS-1:0]    azimuth,
   input  logic [ANGLE_BITS-1:0]    elevation,
   input  logic signed [POS_BITS-1:0] pos_x,
   input  logic signed [POS_BITS-1:0] pos_y,
   output logic                     q_push,
   output pswu_pkg::item_type       q_data,
   input  logic                     q_full
);

   import pswu_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   item_type classified;
   logic     accept;

   assign full   = valid_ff & q_full;
   assign accept = push & ~full;
   assign q_push = valid_ff & ~q_full;
   assign q_data = item_ff;

   always_comb begin
      classified.az    = split_turn({azimuth, {(32 - ANGLE_BITS){1'b0}}});
      classified.el    = split_turn({elevation, {(32 - ANGLE_BITS){1'b0}}});
      classified.pos_x = 32'(pos_x);
      classified.pos_y = 32'(pos_y);
      valid_in = accept | (valid_ff & q_full);
      item_in  = accept ? classified : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ----- hdl/pswu_trig.sv -----
// ----------------------------------------------------------------------------
// pswu_trig
// Pipelined sine/cosine: octant-reduced angle to radians, seven series terms
// of three stages each, then octant swap and quadrant rotation.
// ----------------------------------------------------------------------------
module pswu_trig (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  pswu_pkg::angle_split_type   in_angle,
   output logic                        out_valid,
   output logic signed [31:0]          out_cos,
   output logic signed [31:0]          out_sin
);

   import pswu_pkg::*;

   localparam int NST = 3 * TERM_STEPS;

   logic [NST:0]       v_ff, v_in;
   logic [2:0]         o_ff  [0:NST];
   logic [2:0]         o_in  [0:NST];
   logic [29:0]        r_ff  [0:NST];
   logic [29:0]        r_in  [0:NST];
   logic [30:0]        ts_ff [0:NST];
   logic [30:0]        ts_in [0:NST];
   logic [30:0]        tc_ff [0:NST];
   logic [30:0]        tc_in [0:NST];
   logic signed [31:0] as_ff [0:NST];
   logic signed [31:0] as_in [0:NST];
   logic signed [31:0] ac_ff [0:NST];
   logic signed [31:0] ac_in [0:NST];
   logic [62:0]        r_prod;

   logic               fv_ff, fv_in, ov_ff, ov_in;
   logic [2:0]         fo_ff, fo_in;
   logic signed [31:0] fs_ff, fs_in, fc_ff, fc_in;
   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [31:0] sw_c, sw_s;

   // radians of the reduced angle
   assign r_prod   = {33'd0, in_angle.red} * {30'd0, TWO_PI_Q30} + ROUND_32;
   assign v_in[0]  = in_valid;
   assign o_in[0]  = in_angle.oct;
   assign r_in[0]  = r_prod[61:32];
   assign ts_in[0] = {1'b0, r_prod[61:32]};
   assign tc_in[0] = TRIG_ONE;
   assign as_in[0] = $signed({2'b00, r_prod[61:32]});
   assign ac_in[0] = $signed({1'b0, TRIG_ONE});

   for (genvar i = 1; i <= NST; i++) begin : g_pass
      assign v_in[i] = v_ff[i-1];
      assign o_in[i] = o_ff[i-1];
      assign r_in[i] = r_ff[i-1];
   end

   for (genvar k = 1; k <= TERM_STEPS; k++) begin : g_term
      localparam int P = 3 * k - 3;
      localparam int A = 3 * k - 2;
      localparam int B = 3 * k - 1;
      localparam int C = 3 * k;
      localparam logic [63:0] SM =
         ((64'd1 << SIN_SHIFT[k-1]) + 64'(SIN_DIV[k-1]) - 64'd1) / SIN_DIV[k-1];
      localparam logic [63:0] CM =
         ((64'd1 << COS_SHIFT[k-1]) + 64'(COS_DIV[k-1]) - 64'd1) / COS_DIV[k-1];

      assign ts_in[A] = qmul(ts_ff[P], r_ff[P]);
      assign tc_in[A] = qmul(tc_ff[P], r_ff[P]);
      if (k == 1) begin : g_first
         assign as_in[A] = as_ff[P];
         assign ac_in[A] = ac_ff[P];
      end else if (k % 2 == 0) begin : g_sub
         assign as_in[A] = as_ff[P] - $signed({1'b0, ts_ff[P]});
         assign ac_in[A] = ac_ff[P] - $signed({1'b0, tc_ff[P]});
      end else begin : g_add
         assign as_in[A] = as_ff[P] + $signed({1'b0, ts_ff[P]});
         assign ac_in[A] = ac_ff[P] + $signed({1'b0, tc_ff[P]});
      end

      assign ts_in[B] = qmul(ts_ff[A], r_ff[A]);
      assign tc_in[B] = qmul(tc_ff[A], r_ff[A]);
      assign as_in[B] = as_ff[A];
      assign ac_in[B] = ac_ff[A];

      assign ts_in[C] = recip_div(ts_ff[B], SM[31:0], SIN_SHIFT[k-1]);
      assign tc_in[C] = recip_div(tc_ff[B], CM[31:0], COS_SHIFT[k-1]);
      assign as_in[C] = as_ff[B];
      assign ac_in[C] = ac_ff[B];
   end

   // last term
   if (TERM_STEPS % 2 == 1) begin : g_last_sub
      assign fs_in = as_ff[NST] - $signed({1'b0, ts_ff[NST]});
      assign fc_in = ac_ff[NST] - $signed({1'b0, tc_ff[NST]});
   end else begin : g_last_add
      assign fs_in = as_ff[NST] + $signed({1'b0, ts_ff[NST]});
      assign fc_in = ac_ff[NST] + $signed({1'b0, tc_ff[NST]});
   end
   assign fo_in = o_ff[NST];
   assign fv_in = v_ff[NST];
   assign ov_in = fv_ff;

   always_comb begin
      sw_c = fo_ff[0] ? fs_ff : fc_ff;
      sw_s = fo_ff[0] ? fc_ff : fs_ff;
      case (fo_ff[2:1])
         QUAD_0: begin
            cos_in = sw_c;
            sin_in = sw_s;
         end
         QUAD_1: begin
            cos_in = -sw_s;
            sin_in = sw_c;
         end
         QUAD_2: begin
            cos_in = -sw_c;
            sin_in = -sw_s;
         end
         default: begin
            cos_in = sw_s;
            sin_in = -sw_c;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         fv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= v_in;
         fv_ff <= fv_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= NST; i++) begin
            o_ff[i]  <= o_in[i];
            r_ff[i]  <= r_in[i];
            ts_ff[i] <= ts_in[i];
            tc_ff[i] <= tc_in[i];
            as_ff[i] <= as_in[i];
            ac_ff[i] <= ac_in[i];
         end
         fo_ff  <= fo_in;
         fs_ff  <= fs_in;
         fc_ff  <= fc_in;
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

endmodule

// ----- hdl/pswu_back.sv -----
// ----------------------------------------------------------------------------
// pswu_back
// Execution pipeline: direction trig, direction cosines, phase, phase trig
// and output rounding. The whole pipeline holds while the result queue is full.
// ----------------------------------------------------------------------------
module pswu_back #(
   parameter int OUT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  pswu_pkg::item_type         q_data,
   output logic                       q_pop,
   input  logic                       out_full,
   output logic                       out_push,
   output logic signed [OUT_BITS-1:0] out_re,
   output logic signed [OUT_BITS-1:0] out_im
);

   import pswu_pkg::*;

   logic en;

   logic               az_valid, el_valid, ph_valid;
   logic signed [31:0] az_cos, az_sin, el_cos, el_sin, ph_cos, ph_sin;

   logic signed [31:0] dx_ff [0:TRIG_LAT-1];
   logic signed [31:0] dx_in [0:TRIG_LAT-1];
   logic signed [31:0] dy_ff [0:TRIG_LAT-1];
   logic signed [31:0] dy_in [0:TRIG_LAT-1];

   logic               u1_v_ff, u1_v_in, u2_v_ff, u2_v_in, p1_v_ff, p1_v_in;
   logic               p2_v_ff, p2_v_in, p3_v_ff, p3_v_in, o1_v_ff, o1_v_in;
   logic signed [63:0] pu_ff, pu_in, pv_ff, pv_in;
   logic signed [31:0] u1_x_ff, u1_y_ff, u2_x_ff, u2_y_ff;
   logic signed [31:0] u_ff, u_in, v_ff, v_in;
   logic signed [63:0] x_prod, y_prod, u_round, v_round, re_round, im_round;
   logic [PHASE_W-1:0] px_ff, px_in, py_ff, py_in, phase_sum;
   logic [31:0]        t_ff, t_in;
   angle_split_type    ph_ang_ff, ph_ang_in;
   logic signed [OUT_BITS-1:0] re_ff, re_in, im_ff, im_in;

   assign en    = ~out_full;
   assign q_pop = en & ~q_empty;

   pswu_trig u_trig_az (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (~q_empty),
      .in_angle  (q_data.az),
      .out_valid (az_valid),
      .out_cos   (az_cos),
      .out_sin   (az_sin)
   );

   pswu_trig u_trig_el (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (~q_empty),
      .in_angle  (q_data.el),
      .out_valid (el_valid),
      .out_cos   (el_cos),
      .out_sin   (el_sin)
   );

   // positions ride alongside the direction trig
   assign dx_in[0] = q_data.pos_x;
   assign dy_in[0] = q_data.pos_y;
   for (genvar i = 1; i < TRIG_LAT; i++) begin : g_delay
      assign dx_in[i] = dx_ff[i-1];
      assign dy_in[i] = dy_ff[i-1];
   end

   assign u1_v_in = az_valid & el_valid;
   assign pu_in   = el_sin * az_cos;
   assign pv_in   = el_sin * az_sin;

   assign u2_v_in = u1_v_ff;
   assign u_round = round_away(pu_ff, TRIG_FRAC);
   assign v_round = round_away(pv_ff, TRIG_FRAC);
   assign u_in    = u_round[31:0];
   assign v_in    = v_round[31:0];

   assign p1_v_in = u2_v_ff;
   assign x_prod  = u2_x_ff * u_ff;
   assign y_prod  = u2_y_ff * v_ff;
   assign px_in   = x_prod[PHASE_W-1:0];
   assign py_in   = y_prod[PHASE_W-1:0];

   // negated phase, rounded to turns
   assign p2_v_in   = p1_v_ff;
   assign phase_sum = PHASE_ROUND - px_ff - py_ff;
   assign t_in      = phase_sum[PHASE_W-1:PHASE_SH];

   assign p3_v_in   = p2_v_ff;
   assign ph_ang_in = split_turn(t_ff);

   pswu_trig u_trig_ph (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p3_v_ff),
      .in_angle  (ph_ang_ff),
      .out_valid (ph_valid),
      .out_cos   (ph_cos),
      .out_sin   (ph_sin)
   );

   assign o1_v_in  = ph_valid;
   assign re_round = round_away(64'(ph_cos), 32 - OUT_BITS);
   assign im_round = round_away(64'(ph_sin), 32 - OUT_BITS);
   assign re_in    = re_round[OUT_BITS-1:0];
   assign im_in    = im_round[OUT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         u1_v_ff <= 1'b0;
         u2_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         o1_v_ff <= 1'b0;
      end else if (en) begin
         u1_v_ff <= u1_v_in;
         u2_v_ff <= u2_v_in;
         p1_v_ff <= p1_v_in;
         p2_v_ff <= p2_v_in;
         p3_v_ff <= p3_v_in;
         o1_v_ff <= o1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < TRIG_LAT; i++) begin
            dx_ff[i] <= dx_in[i];
            dy_ff[i] <= dy_in[i];
         end
         pu_ff     <= pu_in;
         pv_ff     <= pv_in;
         u1_x_ff   <= dx_ff[TRIG_LAT-1];
         u1_y_ff   <= dy_ff[TRIG_LAT-1];
         u_ff      <= u_in;
         v_ff      <= v_in;
         u2_x_ff   <= u1_x_ff;
         u2_y_ff   <= u1_y_ff;
         px_ff     <= px_in;
         py_ff     <= py_in;
         t_ff      <= t_in;
         ph_ang_ff <= ph_ang_in;
         re_ff     <= re_in;
         im_ff     <= im_in;
      end
   end

   assign out_push = en & o1_v_ff;
   assign out_re   = re_ff;
   assign out_im   = im_ff;

endmodule

// ----- hdl/planar_steering_weight_unit.sv -----
// ----------------------------------------------------------------------------
// planar_steering_weight_unit
// Narrowband steering weight for one antenna of a planar array per item.
// ----------------------------------------------------------------------------
// Input queue side: drive req_azimuth, req_elevation (fractions of a turn) and
// req_pos_x, req_pos_y (wavelengths, 12 fraction bits) with push; the
// transaction is taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low, rsp_weight_re/rsp_weight_im hold
// cos and sin of the steering phase for the oldest item; pop takes it.
// One transaction per clock is sustained while the result side keeps popping,
// by a fully pipelined datapath with three sine/cosine pipelines (24 stages
// each, seven series terms of three multiply stages). Results leave in
// arrival order.
// When the result side stops popping, the two-entry result queue fills, the
// execution pipeline holds in place, the four-entry item queue fills and
// then full rises; nothing is dropped.
// Reset clears the queues and pipeline valid bits; the block keeps no other
// state and is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module planar_steering_weight_unit #(
   parameter int ANGLE_BITS = 16,
   parameter int POS_BITS   = 20,
   parameter int OUT_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [ANGLE_BITS-1:0]      req_azimuth,
   input  logic [ANGLE_BITS-1:0]      req_elevation,
   input  logic signed [POS_BITS-1:0] req_pos_x,
   input  logic signed [POS_BITS-1:0] req_pos_y,
   output logic                       empty,
   input  logic                       pop,
   output logic signed [OUT_BITS-1:0] rsp_weight_re,
   output logic signed [OUT_BITS-1:0] rsp_weight_im
);

   import pswu_pkg::*;

   localparam int ITEM_W       = $bits(item_type);
   localparam int WEIGHT_LIMIT = 1 << (OUT_BITS - 2);

   logic                       mid_push, mid_full, mid_pop, mid_empty;
   item_type                   front_item, mid_item;
   logic [ITEM_W-1:0]          mid_data;
   logic                       back_push, out_full;
   logic signed [OUT_BITS-1:0] back_re, back_im;
   logic [2*OUT_BITS-1:0]      rsp_data;

   pswu_front #(
      .ANGLE_BITS (ANGLE_BITS),
      .POS_BITS   (POS_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .azimuth   (req_azimuth),
      .elevation (req_elevation),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .q_push    (mid_push),
      .q_data    (front_item),
      .q_full    (mid_full)
   );

   pswu_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (4)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   assign mid_item = mid_data;

   pswu_back #(
      .OUT_BITS (OUT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (mid_empty),
      .q_data   (mid_item),
      .q_pop    (mid_pop),
      .out_full (out_full),
      .out_push (back_push),
      .out_re   (back_re),
      .out_im   (back_im)
   );

   pswu_fifo #(
      .WIDTH (2 * OUT_BITS),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data ({back_re, back_im}),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   assign rsp_weight_re = rsp_data[2*OUT_BITS-1:OUT_BITS];
   assign rsp_weight_im = rsp_data[OUT_BITS-1:0];

   a_back_push_room : assert property (@(posedge clock) disable iff (reset)
      back_push |-> !out_full)
      else $error("result pushed into a full queue");

   a_mid_pop_data : assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("item taken from an empty queue");

   a_full_cause : assert property (@(posedge clock) disable iff (reset)
      full |-> mid_full)
      else $error("full without a full item queue");

   a_weight_range : assert property (@(posedge clock) disable iff (reset)
      !empty |-> ($signed(rsp_weight_re) <= WEIGHT_LIMIT)
              && ($signed(rsp_weight_re) >= -WEIGHT_LIMIT)
              && ($signed(rsp_weight_im) <= WEIGHT_LIMIT)
              && ($signed(rsp_weight_im) >= -WEIGHT_LIMIT))
      else $error("weight outside unit range");

endmodule
